### rtl/mfmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared widths, register indexes, pattern codes and types of the MFM decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

   localparam int MAX_BUFFER_BYTES = 4096;

   localparam int BUF_BYTES_W = 13;
   localparam int CELL_W      = 16;
   localparam int INDEX_W     = 12;
   localparam int BYTE_W      = 8;
   localparam int BIT_CNT_W   = 3;
   localparam int BYTE_CNT_W  = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int LIMIT_W     = (BUF_BYTES_W > BYTE_CNT_W) ? BUF_BYTES_W : BYTE_CNT_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [BUF_BYTES_W-1:0] BUFFER_BYTES_RESET = BUF_BYTES_W'(512);
   localparam logic [CELL_W-1:0]      CELL_LIMIT_RESET   = CELL_W'(12500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_BYTES = 1'b0,
      CSR_CELL_LIMIT   = 1'b1
   } csr_index_type;

   // {previous cell, first cell of pair, second cell of pair}
   localparam logic [2:0] PAT_ZERO_A = 3'b010;
   localparam logic [2:0] PAT_ZERO_B = 3'b100;
   localparam logic [2:0] PAT_ONE_A  = 3'b001;
   localparam logic [2:0] PAT_ONE_B  = 3'b101;

   typedef struct packed {
      logic data;
      logic bad;
   } pair_decode_type;

   typedef struct packed {
      logic                  previous_cell;
      logic                  pair_first_cell;
      logic                  pair_phase;
      logic [BYTE_W-1:0]     byte_shift;
      logic [BIT_CNT_W-1:0]  bit_count;
      logic [BYTE_CNT_W-1:0] byte_count;
      logic [CELL_W-1:0]     cell_count;
      logic                  error_seen;
      logic                  finished;
   } dec_state_type;

   typedef struct packed {
      logic                cell_bit;
      logic                sector_start;
   } cell_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               encoding_error;
      logic               last;
   } byte_result_type;

   // handshake from decode to the input and output registers
   typedef struct packed {
      logic emit;
      logic advance;
   } dec_ctrl_type;

   function automatic pair_decode_type decode_pair(input logic [2:0] pattern);
      pair_decode_type res;
      res = '0;
      unique case (pattern) inside
         PAT_ZERO_A, PAT_ZERO_B: res.data = 1'b0;
         PAT_ONE_A, PAT_ONE_B:   res.data = 1'b1;
         default:                res.bad  = 1'b1;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/mfmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_if
// Valid/ready channels of the MFM decoder: cell input, byte output, CSR write.
// ----------------------------------------------------------------------------
interface mfmd_req_if;
   logic valid;
   logic ready;
   logic cell_bit;
   logic sector_start;

   modport source (output valid, output cell_bit, output sector_start, input ready);
   modport sink   (input valid, input cell_bit, input sector_start, output ready);
endinterface

interface mfmd_rsp_if
   import mfmd_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               encoding_error;
   logic               last;

   modport source (output valid, output data_byte, output byte_index,
                   output encoding_error, output last, input ready);
   modport sink   (input valid, input data_byte, input byte_index,
                   input encoding_error, input last, output ready);
endinterface

interface mfmd_csr_if
   import mfmd_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/mfm_bit_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfm_bit_decoder_core
// MFM sector-read decoder: raw cells in, decoded bytes with index out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw cell per beat; sector_start = 1 on a beat clears
//   the sector state before that cell is decoded. rsp_chan carries one beat
//   per completed byte: data (first bit in the MSB), buffer index, sticky
//   encoding error and last. csr_chan writes buffer_bytes (index 0) and
//   cell_limit (index 1); always ready, write only while the core is idle.
//   Throughput: one cell per cycle unless a byte is due behind a stall.
//   Path: a byte reaches rsp_chan through the input register, then
//   decode into the output register, after its final cell is accepted.
//   Once the buffer is full or the cell limit is used up, cells are taken
//   and dropped until the next sector_start.
//   When rsp_chan stalls, the output register holds its byte; the input
//   register keeps filling and cells that complete no byte keep flowing,
//   so req_chan drops ready only when a second byte is due behind a stall.
//   Reset: synchronous; clears sector state and both channel registers and
//   restores buffer_bytes = 512, cell_limit = 12500.
// ----------------------------------------------------------------------------
module mfm_bit_decoder_core
   import mfmd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mfmd_req_if.sink  req_chan,
   mfmd_rsp_if.source rsp_chan,
   mfmd_csr_if.sink  csr_chan
);

   logic [BUF_BYTES_W-1:0] buffer_bytes_ff, buffer_bytes_in;
   logic [CELL_W-1:0]      cell_limit_ff, cell_limit_in;
   logic [LIMIT_W-1:0]     limit_wide;
   logic [BYTE_CNT_W-1:0]  byte_limit;

   cell_item_type   in_item, item;
   logic            item_valid;
   logic            out_free;
   dec_ctrl_type    ctrl;
   byte_result_type result, out_result;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      buffer_bytes_in = buffer_bytes_ff;
      cell_limit_in   = cell_limit_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_BUFFER_BYTES: buffer_bytes_in = csr_chan.data[BUF_BYTES_W-1:0];
            CSR_CELL_LIMIT:   cell_limit_in   = csr_chan.data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff <= BUFFER_BYTES_RESET;
         cell_limit_ff   <= CELL_LIMIT_RESET;
      end else begin
         buffer_bytes_ff <= buffer_bytes_in;
         cell_limit_ff   <= cell_limit_in;
      end
   end

   // zero acts as one, and sizes past the buffer saturate
   always_comb begin
      limit_wide = LIMIT_W'(buffer_bytes_ff);
      if (buffer_bytes_ff == '0) begin
         limit_wide = LIMIT_W'(1);
      end else if (limit_wide > LIMIT_W'(MAX_BUFFER_BYTES)) begin
         limit_wide = LIMIT_W'(MAX_BUFFER_BYTES);
      end
      byte_limit = BYTE_CNT_W'(limit_wide);
   end

   assign in_item.cell_bit     = req_chan.cell_bit;
   assign in_item.sector_start = req_chan.sector_start;

   mfmd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (in_item),
      .advance    (ctrl.advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mfmd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .byte_limit (byte_limit),
      .cell_limit (cell_limit_ff),
      .ctrl       (ctrl),
      .result     (result)
   );

   mfmd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .result     (result),
      .out_free   (out_free),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (out_result)
   );

   assign rsp_chan.data_byte      = out_result.data_byte;
   assign rsp_chan.byte_index     = out_result.byte_index;
   assign rsp_chan.encoding_error = out_result.encoding_error;
   assign rsp_chan.last           = out_result.last;

endmodule
`default_nettype wire

### rtl/mfmd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_in_stage
// Input register: holds one accepted cell beat until decode consumes it.
// ----------------------------------------------------------------------------
module mfmd_in_stage
   import mfmd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire cell_item_type in_item,
   input  wire logic          advance,
   output      logic          item_valid,
   output      cell_item_type item
);

   logic          valid_ff, valid_in;
   cell_item_type item_ff, item_in;

   always_comb begin
      in_ready = !valid_ff || advance;
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

### rtl/mfmd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_decode
// Sector decode state: pairs cells, maps patterns to data bits, packs bytes,
// and tracks the byte and cell limits.
// ----------------------------------------------------------------------------
module mfmd_decode
   import mfmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire cell_item_type         item,
   input  wire logic                  out_free,
   input  wire logic [BYTE_CNT_W-1:0] byte_limit,
   input  wire logic [CELL_W-1:0]     cell_limit,
   output      dec_ctrl_type          ctrl,
   output      byte_result_type       result
);

   dec_state_type   state_ff, state_in;
   dec_state_type   cur;
   pair_decode_type pair;
   logic            taken;
   logic [BYTE_CNT_W-1:0] byte_count_nxt;

   always_comb begin
      // sector_start clears everything before this cell is looked at
      cur = item.sector_start ? '0 : state_ff;
      taken = !cur.finished && (cur.cell_count < cell_limit);
      pair  = decode_pair({cur.previous_cell, cur.pair_first_cell, item.cell_bit});
      byte_count_nxt = cur.byte_count + 1'b1;

      state_in  = cur;
      ctrl.emit = 1'b0;

      if (!cur.finished) begin
         if (!taken) begin
            state_in.finished = 1'b1;
         end else begin
            state_in.cell_count = cur.cell_count + 1'b1;
            if (!cur.pair_phase) begin
               state_in.pair_first_cell = item.cell_bit;
               state_in.pair_phase      = 1'b1;
            end else begin
               state_in.pair_phase    = 1'b0;
               state_in.previous_cell = item.cell_bit;
               state_in.error_seen    = cur.error_seen | pair.bad;
               state_in.byte_shift    = {cur.byte_shift[BYTE_W-2:0], pair.data};
               state_in.bit_count     = cur.bit_count + 1'b1;
               if (cur.bit_count == '1) begin
                  ctrl.emit           = 1'b1;
                  state_in.byte_count = byte_count_nxt;
                  state_in.byte_shift = '0;
                  if (byte_count_nxt >= byte_limit) begin
                     state_in.finished = 1'b1;
                  end
               end
            end
            if (state_in.cell_count >= cell_limit) begin
               state_in.finished = 1'b1;
            end
         end
      end

      // a beat with no byte never waits for the output register
      ctrl.advance = item_valid && (out_free || !ctrl.emit);

      result.data_byte      = {cur.byte_shift[BYTE_W-2:0], pair.data};
      result.byte_index     = INDEX_W'(cur.byte_count);
      result.encoding_error = cur.error_seen | pair.bad;
      result.last           = (byte_count_nxt >= byte_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctrl.advance) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mfmd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_out_stage
// Output register: holds one decoded byte until the receiver takes the beat.
// ----------------------------------------------------------------------------
module mfmd_out_stage
   import mfmd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dec_ctrl_type    ctrl,
   input  wire byte_result_type result,
   output      logic            out_free,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      byte_result_type out_result
);

   logic            valid_ff, valid_in;
   byte_result_type result_ff, result_in;
   logic            load;

   always_comb begin
      out_free  = !valid_ff || out_ready;
      load      = ctrl.advance && ctrl.emit;
      valid_in  = valid_ff && !out_ready;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

### rtl/mfmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmd_checker
// Port-level checks of the MFM decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module mfmd_checker
   import mfmd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [BYTE_W-1:0]  rsp_data_byte,
   input wire logic [INDEX_W-1:0] rsp_byte_index,
   input wire logic               csr_ready
);

   // nothing comes out in the cycle after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // an empty output register never blocks the input
   a_req_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with output register empty");

   // a stalled byte beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
                                  && $stable(rsp_byte_index))
      else $error("rsp beat changed while stalled");

   // register writes are never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");

endmodule

bind mfm_bit_decoder_core mfmd_checker u_mfmd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_data_byte  (rsp_chan.data_byte),
   .rsp_byte_index (rsp_chan.byte_index),
   .csr_ready      (csr_chan.ready)
);
`default_nettype wire

### verif/mfmd_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_byte_checker
// Watches the cell, byte and CSR channels of the MFM decoder, keeps its own
// decode of every accepted cell and compares each byte beat with the oldest
// byte it predicted.
// ----------------------------------------------------------------------------
module mfmd_byte_checker
   import mfmd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mfmd_req_if       req_chan,
   mfmd_rsp_if       rsp_chan,
   mfmd_csr_if       csr_chan,
   output int        fail_count,
   output int        bytes_pending
);

   logic [BUF_BYTES_W-1:0] buffer_size;
   logic [CELL_W-1:0]      cell_budget;

   logic                   last_cell;
   logic                   pair_head;
   logic                   mid_pair;
   logic [BYTE_W-1:0]      shifter;
   logic [BIT_CNT_W-1:0]   bit_slot;
   int unsigned            byte_total;
   logic [CELL_W-1:0]      cells_used;
   logic                   error_flag;
   logic                   read_over;

   byte_result_type        decoded_bytes[$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: byte mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void clear_sector();
      last_cell  = 1'b0;
      pair_head  = 1'b0;
      mid_pair   = 1'b0;
      shifter    = '0;
      bit_slot   = '0;
      byte_total = 0;
      cells_used = '0;
      error_flag = 1'b0;
      read_over  = 1'b0;
   endfunction

   task automatic decode_cell(input logic cell_val, input logic start);
      logic [2:0]      pattern;
      logic            bit_val;
      int unsigned     fill;
      byte_result_type res;
      if (start)
         clear_sector();
      if (read_over)
         return;
      if (cells_used >= cell_budget) begin
         read_over = 1'b1;
         return;
      end
      cells_used = cells_used + 1'b1;
      if (!mid_pair) begin
         pair_head = cell_val;
         mid_pair  = 1'b1;
      end else begin
         mid_pair = 1'b0;
         pattern  = {last_cell, pair_head, cell_val};
         case (pattern)
            PAT_ZERO_A, PAT_ZERO_B: bit_val = 1'b0;
            PAT_ONE_A, PAT_ONE_B:   bit_val = 1'b1;
            default: begin
               // bad clocking: sticky error, bit decodes as zero
               bit_val    = 1'b0;
               error_flag = 1'b1;
            end
         endcase
         last_cell = cell_val;
         shifter   = {shifter[BYTE_W-2:0], bit_val};
         bit_slot  = bit_slot + 1'b1;
         if (bit_slot == '0) begin
            if (buffer_size == '0)
               fill = 1;
            else if (buffer_size > MAX_BUFFER_BYTES)
               fill = MAX_BUFFER_BYTES;
            else
               fill = buffer_size;
            res.data_byte      = shifter;
            res.byte_index     = byte_total[INDEX_W-1:0];
            res.encoding_error = error_flag;
            byte_total++;
            shifter  = '0;
            res.last = (byte_total >= fill);
            if (res.last)
               read_over = 1'b1;
            decoded_bytes.push_back(res);
         end
      end
      if (cells_used >= cell_budget)
         read_over = 1'b1;
   endtask

   always @(posedge clock) begin
      byte_result_type want;
      string           diffs;
      if (reset) begin
         buffer_size = BUFFER_BYTES_RESET;
         cell_budget = CELL_LIMIT_RESET;
         clear_sector();
         decoded_bytes.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_index_type'(csr_chan.index))
               CSR_BUFFER_BYTES: buffer_size = csr_chan.data[BUF_BYTES_W-1:0];
               CSR_CELL_LIMIT:   cell_budget = csr_chan.data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            decode_cell(req_chan.cell_bit, req_chan.sector_start);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decoded_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, data %02h index %0d",
                                         rsp_chan.data_byte, rsp_chan.byte_index));
            end else begin
               want  = decoded_bytes.pop_front();
               diffs = "";
               if (rsp_chan.data_byte !== want.data_byte)
                  diffs = {diffs, $sformatf(" data %02h/%02h",
                                            rsp_chan.data_byte, want.data_byte)};
               if (rsp_chan.byte_index !== want.byte_index)
                  diffs = {diffs, $sformatf(" index %0d/%0d",
                                            rsp_chan.byte_index, want.byte_index)};
               if (rsp_chan.encoding_error !== want.encoding_error)
                  diffs = {diffs, $sformatf(" error %b/%b",
                                            rsp_chan.encoding_error, want.encoding_error)};
               if (rsp_chan.last !== want.last)
                  diffs = {diffs, $sformatf(" last %b/%b", rsp_chan.last, want.last)};
               if (diffs != "")
                  report_mismatch($sformatf("byte %0d got/expected:%s",
                                            want.byte_index, diffs));
            end
         end
      end
      bytes_pending <= decoded_bytes.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives MFM cell streams into mfm_bit_decoder_core: a short directed run of
// valid and invalid clock patterns, then sectors of well-formed MFM with
// random data, corrupted and cut-off sectors and raw noise, under a series
// of buffer sizes and cell limits. The byte checker judges every byte beat.
// ----------------------------------------------------------------------------
module testbench;
   import mfmd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 1950;
   // cells MSB first: 000, 011, 111, 110 then 010, 010, 001, 101
   localparam logic [15:0] BAD_CLOCK_RUN = 16'b0011_1110_1010_0101;

   logic clock = 1'b0;
   logic reset;
   logic rsp_ready_q = 1'b0;
   bit   steady;
   logic enc_prev;
   int   cells_sent;
   int   quiet_cycles;
   int   fail_count;
   int   bytes_pending;

   mfmd_req_if req_chan ();
   mfmd_rsp_if rsp_chan ();
   mfmd_csr_if csr_chan ();

   mfm_bit_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   mfmd_byte_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   always #1 clock = ~clock;

   assign rsp_chan.ready = rsp_ready_q;

   always @(posedge clock) begin
      rsp_ready_q <= steady || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves valid high after the beat; the next call or settle() decides
   task automatic send_cell(input logic cell_val, input logic start);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cell_bit     <= cell_val;
      req_chan.sector_start <= start;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      cells_sent++;
   endtask

   // MFM encode: 1 -> 01, 0 -> 10 after a 0 cell, 00 after a 1 cell
   task automatic send_byte(input logic [7:0] value, input logic start, input int bad_cell);
      logic c0;
      logic c1;
      for (int k = 0; k < 8; k++) begin
         c1 = value[7 - k];
         c0 = c1 ? 1'b0 : ~enc_prev;
         send_cell(c0 ^ (2 * k == bad_cell), start && (k == 0));
         send_cell(c1 ^ (2 * k + 1 == bad_cell), 1'b0);
         enc_prev = c1;
      end
   endtask

   task automatic run_sector(input int n_bytes, input bit corrupt);
      int bad_byte;
      bad_byte = corrupt ? int'($urandom_range(0, n_bytes - 1)) : -1;
      enc_prev = 1'b0;
      for (int b = 0; b < n_bytes; b++) begin
         logic [7:0] value;
         case ($urandom_range(0, 5))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'($urandom);
         endcase
         send_byte(value, b == 0, (b == bad_byte) ? int'($urandom_range(0, 15)) : -1);
      end
   endtask

   // hold the sender until every predicted byte is out, then let the pipe empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
   endtask

   initial begin
      int                    phase;
      int                    phase_start;
      int                    budget;
      int                    saved;
      logic [CSR_DATA_W-1:0] buf_val;
      logic [CSR_DATA_W-1:0] lim_val;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.cell_bit     <= 1'b0;
      req_chan.sector_start <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= CSR_BUFFER_BYTES;
      csr_chan.data         <= '0;
      steady                <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all four valid patterns in one byte, then a dangling half pair cut
      // by a sector start that runs all four bad clock patterns
      enc_prev = 1'b0;
      send_byte(8'hCA, 1'b1, -1);
      send_cell(1'b1, 1'b0);
      for (int k = 15; k >= 0; k--)
         send_cell(BAD_CLOCK_RUN[k], k == 15);

      phase = 0;
      while (cells_sent < RANDOM_ITEMS) begin
         settle();
         case (phase)
            0: begin buf_val = 16'd1;    lim_val = 16'hFFFF; end
            1: begin buf_val = 16'd0;    lim_val = 16'hFFFF; end
            2: begin buf_val = 16'd5;    lim_val = 16'd16;   end
            3: begin buf_val = 16'd2;    lim_val = 16'd17;   end
            4: begin buf_val = 16'hFFFF; lim_val = 16'd0;    end
            5: begin buf_val = 16'd4096; lim_val = 16'd1;    end
            6: begin buf_val = 16'd3;    lim_val = 16'd40;   end
            default: begin
               case ($urandom_range(0, 9))
                  0:       buf_val = 16'd0;
                  1:       buf_val = 16'(MAX_BUFFER_BYTES);
                  2:       buf_val = 16'($urandom);
                  default: buf_val = 16'($urandom_range(1, 4));
               endcase
               case ($urandom_range(0, 9))
                  0:       lim_val = 16'hFFFF;
                  1:       lim_val = 16'd12500;
                  2:       lim_val = 16'd0;
                  default: lim_val = 16'($urandom_range(1, 400));
               endcase
            end
         endcase
         write_reg(CSR_BUFFER_BYTES, buf_val);
         write_reg(CSR_CELL_LIMIT, lim_val);
         csr_chan.valid <= 1'b0;
         steady <= (phase >= 8 && phase < 11);
         budget = (lim_val == 0) ? 16 : 150;
         phase_start = cells_sent;
         while (cells_sent - phase_start < budget) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 40))
                  send_cell(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
            end else begin
               run_sector($urandom_range(1, 6), $urandom_range(0, 3) == 0);
               if ($urandom_range(0, 2) == 0) begin
                  // trailing cells, mostly dropped once the read is over
                  saved = cells_sent;
                  repeat ($urandom_range(1, 6))
                     send_cell(1'($urandom_range(0, 1)), 1'b0);
                  cells_sent = saved;
               end
            end
         end
         phase++;
      end

      settle();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
